[rtl/core/hdip_pkg.sv]
`default_nettype none

package hdip_pkg;

    localparam logic [7:0] LONG_MARK = 8'hFE;
    localparam logic [1:0] SIZE_MASK = 2'h3;
    localparam logic [3:0] NIB_MASK  = 4'hF;

    localparam logic [2:0] TYPE_MAIN     = 3'd0;
    localparam logic [2:0] TYPE_GLOBAL   = 3'd1;
    localparam logic [2:0] TYPE_LOCAL    = 3'd2;
    localparam logic [2:0] TYPE_RESERVED = 3'd3;
    localparam logic [2:0] TYPE_LONG     = 3'd4;

    localparam logic [4:0] TAG_NONE = 5'd0;

    localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;

    typedef struct packed {
        logic [2:0]        item_type;
        logic [4:0]        item_tag;
        logic [2:0]        payload_size;
        logic [31:0]       payload_unsigned;
        logic signed [31:0] payload_signed;
        logic [2:0]        consumed_bytes;
        logic              truncated;
    } result_t;

    typedef struct packed {
        logic [2:0] item_type;
        logic [4:0] item_tag;
        logic [2:0] payload_size;
    } header_t;

    function automatic logic [4:0] tag_lookup(input logic [2:0] kind, input logic [3:0] nib);
        logic [4:0] tag;
        tag = TAG_NONE;
        case (kind)
            TYPE_MAIN:
            begin
                if (nib >= 4'd8 && nib <= 4'd12)
                begin
                    tag = 5'({1'b0, nib} - 5'd7);
                end
            end
            TYPE_GLOBAL:
            begin
                if (nib <= 4'd11)
                begin
                    tag = 5'({1'b0, nib} + 5'd6);
                end
            end
            TYPE_LOCAL:
            begin
                if (nib <= 4'd5)
                begin
                    tag = 5'({1'b0, nib} + 5'd18);
                end
                else if (nib >= 4'd7 && nib <= 4'd10)
                begin
                    tag = 5'({1'b0, nib} + 5'd17);
                end
            end
            default:
            begin
                tag = TAG_NONE;
            end
        endcase
        return tag;
    endfunction

    function automatic logic signed [31:0] sign_extend(input logic [31:0] v,
                                                       input logic [2:0] size);
        logic signed [31:0] r;
        case (size)
            3'd1:    r = {{24{v[7]}}, v[7:0]};
            3'd2:    r = {{16{v[15]}}, v[15:0]};
            3'd4:    r = v;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/hid_descriptor_item_parser_core.sv]
// An accepted byte is held in the input register; the item it completes is
// held in the result register. Throughput: 1 byte per cycle unless out_stall
// holds a pending item; set by the single decode/assembly stage between them.
// Reset (rst_n low, asynchronous): parser expects a header, all valid
// flags and assembly state cleared.
`default_nettype none

module hid_descriptor_item_parser_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       item_type,
    output logic [4:0]       item_tag,
    output logic [2:0]       payload_size,
    output logic [31:0]      payload_unsigned,
    output logic signed [31:0] payload_signed,
    output logic [2:0]       consumed_bytes,
    output logic             truncated
);

    logic              s1_valid_reg, s1_valid_next;
    logic [7:0]        s1_byte_reg;
    logic              s1_eod_reg;
    logic              out_valid_reg, out_valid_next;
    hdip_pkg::result_t out_reg;

    logic              out_free;
    logic              advance;
    logic              in_accept;
    logic              emit;
    hdip_pkg::header_t header;
    hdip_pkg::result_t result;

    hdip_decode u_decode
    (
        .in_byte (s1_byte_reg),
        .header  (header)
    );

    hdip_assemble u_assemble
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_byte     (s1_byte_reg),
        .end_of_data (s1_eod_reg),
        .header      (header),
        .emit        (emit),
        .result      (result)
    );

    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        advance   = s1_valid_reg && out_free;
        in_stall  = s1_valid_reg && !out_free;
        in_accept = in_valid && !in_stall;

        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = advance && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= in_byte;
            s1_eod_reg  <= end_of_data;
        end
        if (advance && emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign item_type        = out_reg.item_type;
    assign item_tag         = out_reg.item_tag;
    assign payload_size     = out_reg.payload_size;
    assign payload_unsigned = out_reg.payload_unsigned;
    assign payload_signed   = out_reg.payload_signed;
    assign consumed_bytes   = out_reg.consumed_bytes;
    assign truncated        = out_reg.truncated;

endmodule

`default_nettype wire

[rtl/core/hdip_decode.sv]
`default_nettype none

module hdip_decode
(
    input  wire logic [7:0]       in_byte,
    output hdip_pkg::header_t     header
);

    logic [1:0] size_code;
    logic [2:0] kind;
    logic [3:0] nib;

    always_comb
    begin
        size_code = in_byte[1:0] & hdip_pkg::SIZE_MASK;
        kind      = {1'b0, in_byte[3:2] & hdip_pkg::SIZE_MASK};
        nib       = in_byte[7:4] & hdip_pkg::NIB_MASK;
        header.item_type    = kind;
        header.item_tag     = hdip_pkg::tag_lookup(kind, nib);
        header.payload_size = (size_code == hdip_pkg::SIZE_CODE_FOUR) ? 3'd4
                                                                      : {1'b0, size_code};
    end

endmodule

`default_nettype wire

[rtl/core/hdip_assemble.sv]
`default_nettype none

module hdip_assemble
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic [7:0]       in_byte,
    input  wire logic             end_of_data,
    input  wire hdip_pkg::header_t header,
    output logic                  emit,
    output hdip_pkg::result_t     result
);

    logic        in_payload_reg, in_payload_next;
    logic [2:0]  bytes_left_reg, bytes_left_next;
    logic [2:0]  held_size_reg, held_size_next;
    logic [2:0]  held_type_reg, held_type_next;
    logic [4:0]  held_tag_reg, held_tag_next;
    logic [31:0] accum_reg, accum_next;

    logic [1:0]  pos;
    logic [2:0]  left_dec;
    logic [31:0] merged;

    always_comb
    begin
        pos      = 2'(held_size_reg - bytes_left_reg);
        left_dec = bytes_left_reg - 3'd1;
        case (pos)
            2'd0:    merged = accum_reg | {24'd0, in_byte};
            2'd1:    merged = accum_reg | {16'd0, in_byte, 8'd0};
            2'd2:    merged = accum_reg | {8'd0, in_byte, 16'd0};
            default: merged = accum_reg | {in_byte, 24'd0};
        endcase

        in_payload_next = in_payload_reg;
        bytes_left_next = bytes_left_reg;
        held_size_next  = held_size_reg;
        held_type_next  = held_type_reg;
        held_tag_next   = held_tag_reg;
        accum_next      = accum_reg;

        emit                    = 1'b0;
        result.item_type        = held_type_reg;
        result.item_tag         = held_tag_reg;
        result.payload_size     = held_size_reg;
        result.payload_unsigned = '0;
        result.payload_signed   = '0;
        result.consumed_bytes   = 3'(held_size_reg + 3'd1);
        result.truncated        = 1'b0;

        if (!in_payload_reg)
        begin
            result.item_type      = header.item_type;
            result.item_tag       = header.item_tag;
            result.payload_size   = header.payload_size;
            result.consumed_bytes = 3'(header.payload_size + 3'd1);
            if (in_byte == hdip_pkg::LONG_MARK)
            begin
                emit                  = 1'b1;
                result.item_type      = hdip_pkg::TYPE_LONG;
                result.item_tag       = hdip_pkg::TAG_NONE;
                result.payload_size   = 3'd0;
                result.consumed_bytes = 3'd0;
            end
            else if (header.payload_size == 3'd0)
            begin
                emit = 1'b1;
            end
            else if (end_of_data)
            begin
                emit             = 1'b1;
                result.truncated = 1'b1;
            end
            else
            begin
                held_size_next  = header.payload_size;
                held_type_next  = header.item_type;
                held_tag_next   = header.item_tag;
                bytes_left_next = header.payload_size;
                accum_next      = '0;
                in_payload_next = 1'b1;
            end
        end
        else
        begin
            accum_next      = merged;
            bytes_left_next = left_dec;
            if (left_dec == 3'd0)
            begin
                emit                    = 1'b1;
                result.payload_unsigned = merged;
                result.payload_signed   = hdip_pkg::sign_extend(merged, held_size_reg);
            end
            else if (end_of_data)
            begin
                emit             = 1'b1;
                result.truncated = 1'b1;
            end
        end

        if (emit)
        begin
            in_payload_next = 1'b0;
            bytes_left_next = 3'd0;
            accum_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg <= 1'b0;
            bytes_left_reg <= 3'd0;
            held_size_reg  <= 3'd0;
            held_type_reg  <= 3'd0;
            held_tag_reg   <= 5'd0;
            accum_reg      <= '0;
        end
        else if (advance)
        begin
            in_payload_reg <= in_payload_next;
            bytes_left_reg <= bytes_left_next;
            held_size_reg  <= held_size_next;
            held_type_reg  <= held_type_next;
            held_tag_reg   <= held_tag_next;
            accum_reg      <= accum_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/hdip_checker.sv]
`default_nettype none

module hdip_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  item_type,
    input wire logic [4:0]  item_tag,
    input wire logic [2:0]  payload_size,
    input wire logic [31:0] payload_unsigned,
    input wire logic [31:0] payload_signed,
    input wire logic [2:0]  consumed_bytes,
    input wire logic        truncated
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_unsigned)
            && $stable(item_type) && $stable(consumed_bytes))
        else $error("stalled item changed");

    a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> payload_unsigned == 32'd0 && payload_signed == 32'd0)
        else $error("truncated item carries payload");

    a_long: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_type == hdip_pkg::TYPE_LONG |->
            consumed_bytes == 3'd0 && item_tag == hdip_pkg::TAG_NONE && !truncated)
        else $error("long item fields wrong");

    a_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_type != hdip_pkg::TYPE_LONG |->
            consumed_bytes == 3'(payload_size + 3'd1))
        else $error("consumed byte count wrong");

    a_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_size == 3'd0 |-> payload_signed == 32'd0)
        else $error("empty item has signed payload");

endmodule

bind hid_descriptor_item_parser_core hdip_checker u_hdip_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .item_type        (item_type),
    .item_tag         (item_tag),
    .payload_size     (payload_size),
    .payload_unsigned (payload_unsigned),
    .payload_signed   (payload_signed),
    .consumed_bytes   (consumed_bytes),
    .truncated        (truncated)
);

`default_nettype wire

[dv/hid_descriptor_item_parser_core_checker.sv]
`timescale 1ns / 100ps

module hid_descriptor_item_parser_core_checker
    import hdip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [7:0]        in_byte,
    input  logic              end_of_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [2:0]        item_type,
    input  logic [4:0]        item_tag,
    input  logic [2:0]        payload_size,
    input  logic [31:0]       payload_unsigned,
    input  logic signed [31:0] payload_signed,
    input  logic [2:0]        consumed_bytes,
    input  logic              truncated,
    output int                mismatches,
    output int                waiting
);

    result_t     expected_items [$];

    logic        pl_active;
    logic [2:0]  pl_left;
    logic [2:0]  pl_size;
    logic [2:0]  pl_type;
    logic [4:0]  pl_tag;
    logic [31:0] pl_accum;

    function automatic logic [4:0] flat_tag(input logic [2:0] kind, input logic [3:0] nib);
        logic [4:0] t;
        t = TAG_NONE;
        case (kind)
            TYPE_MAIN:
            begin
                if (nib >= 4'd8 && nib <= 4'd12)
                begin
                    t = 5'(nib) - 5'd7;
                end
            end
            TYPE_GLOBAL:
            begin
                if (nib < 4'd12)
                begin
                    t = 5'd6 + 5'(nib);
                end
            end
            TYPE_LOCAL:
            begin
                if (nib < 4'd6)
                begin
                    t = 5'd18 + 5'(nib);
                end
                else if (nib > 4'd6 && nib < 4'd11)
                begin
                    t = 5'd17 + 5'(nib);
                end
            end
            default:
            begin
                t = TAG_NONE;
            end
        endcase
        return t;
    endfunction

    function automatic logic [31:0] widen(input logic [31:0] v, input logic [2:0] size);
        logic [31:0] r;
        r = '0;
        if (size == 3'd1)
        begin
            r = v[7] ? (v | 32'hFFFF_FF00) : (v & 32'h0000_00FF);
        end
        else if (size == 3'd2)
        begin
            r = v[15] ? (v | 32'hFFFF_0000) : (v & 32'h0000_FFFF);
        end
        else if (size == 3'd4)
        begin
            r = v;
        end
        return r;
    endfunction

    task automatic queue_item(input logic [2:0] ty, input logic [4:0] tg, input logic [2:0] sz,
                              input logic [31:0] pay, input logic [2:0] used,
                              input logic cut);
        result_t r;
        r.item_type        = ty;
        r.item_tag         = tg;
        r.payload_size     = sz;
        r.payload_unsigned = cut ? 32'd0 : pay;
        r.payload_signed   = cut ? 32'sd0 : $signed(widen(pay, sz));
        r.consumed_bytes   = used;
        r.truncated        = cut;
        expected_items.push_back(r);
        pl_active = 1'b0;
        pl_left   = 3'd0;
        pl_accum  = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [2:0] sz;
        logic [2:0] ty;
        logic [4:0] tg;
        logic [1:0] pos;
        if (!pl_active)
        begin
            if (b == LONG_MARK)
            begin
                queue_item(TYPE_LONG, TAG_NONE, 3'd0, 32'd0, 3'd0, 1'b0);
            end
            else
            begin
                sz = (b[1:0] == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, b[1:0]};
                ty = {1'b0, b[3:2]};
                tg = flat_tag(ty, b[7:4]);
                if (sz == 3'd0)
                begin
                    queue_item(ty, tg, 3'd0, 32'd0, 3'd1, 1'b0);
                end
                else if (last)
                begin
                    queue_item(ty, tg, sz, 32'd0, sz + 3'd1, 1'b1);
                end
                else
                begin
                    pl_size   = sz;
                    pl_type   = ty;
                    pl_tag    = tg;
                    pl_left   = sz;
                    pl_accum  = '0;
                    pl_active = 1'b1;
                end
            end
        end
        else
        begin
            pos = 2'(pl_size - pl_left);
            pl_accum = pl_accum | ({24'd0, b} << (8 * pos));
            pl_left = pl_left - 3'd1;
            if (pl_left == 3'd0)
            begin
                queue_item(pl_type, pl_tag, pl_size, pl_accum, pl_size + 3'd1, 1'b0);
            end
            else if (last)
            begin
                queue_item(pl_type, pl_tag, pl_size, 32'd0, pl_size + 3'd1, 1'b1);
            end
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            pl_active = 1'b0;
            pl_left   = 3'd0;
            pl_size   = 3'd0;
            pl_type   = 3'd0;
            pl_tag    = 5'd0;
            pl_accum  = '0;
            expected_items.delete();
            waiting   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_items.size() == 0)
                begin
                    report("unexpected item", {29'd0, item_type}, 32'd0);
                end
                else
                begin
                    e = expected_items.pop_front();
                    if (item_type !== e.item_type)
                        report("item_type", {29'd0, item_type}, {29'd0, e.item_type});
                    if (item_tag !== e.item_tag)
                        report("item_tag", {27'd0, item_tag}, {27'd0, e.item_tag});
                    if (payload_size !== e.payload_size)
                        report("payload_size", {29'd0, payload_size}, {29'd0, e.payload_size});
                    if (payload_unsigned !== e.payload_unsigned)
                        report("payload_unsigned", payload_unsigned, e.payload_unsigned);
                    if (payload_signed !== e.payload_signed)
                        report("payload_signed", payload_signed, e.payload_signed);
                    if (consumed_bytes !== e.consumed_bytes)
                        report("consumed_bytes", {29'd0, consumed_bytes},
                               {29'd0, e.consumed_bytes});
                    if (truncated !== e.truncated)
                        report("truncated", {31'd0, truncated}, {31'd0, e.truncated});
                end
            end
            if (in_valid && !in_stall)
            begin
                parse_byte(in_byte, end_of_data);
            end
            waiting = expected_items.size();
        end
    end

endmodule

[dv/hid_descriptor_item_parser_core_tb.sv]
`timescale 1ns / 100ps

module hid_descriptor_item_parser_core_tb;
    import hdip_pkg::*;

    localparam int BYTES_PER_PHASE = 650;
    localparam int QUIET_LIMIT     = 1000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        in_byte;
    logic              end_of_data;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [2:0]        item_type;
    logic [4:0]        item_tag;
    logic [2:0]        payload_size;
    logic [31:0]       payload_unsigned;
    logic signed [31:0] payload_signed;
    logic [2:0]        consumed_bytes;
    logic              truncated;

    int                mismatches;
    int                waiting;
    int                snd_idle;
    int                rcv_idle;
    int                sent;
    int                quiet = 0;

    hid_descriptor_item_parser_core u_top
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_byte          (in_byte),
        .end_of_data      (end_of_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .item_type        (item_type),
        .item_tag         (item_tag),
        .payload_size     (payload_size),
        .payload_unsigned (payload_unsigned),
        .payload_signed   (payload_signed),
        .consumed_bytes   (consumed_bytes),
        .truncated        (truncated)
    );

    hid_descriptor_item_parser_core_checker u_chk
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_byte          (in_byte),
        .end_of_data      (end_of_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .item_type        (item_type),
        .item_tag         (item_tag),
        .payload_size     (payload_size),
        .payload_unsigned (payload_unsigned),
        .payload_signed   (payload_signed),
        .consumed_bytes   (consumed_bytes),
        .truncated        (truncated),
        .mismatches       (mismatches),
        .waiting          (waiting)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < rcv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet <= 0;
            end
            else if (quiet + 1 >= QUIET_LIMIT)
            begin
                $display("hid_descriptor_item_parser_core_tb NOT OK");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eod);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_data <= eod;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    // hold the sender off until every pending item has come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (waiting != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic send_item();
        logic [7:0] hdr;
        int         sz;
        int         cut;
        logic       eod;
        hdr = 8'($urandom_range(255));
        if ($urandom_range(15) == 0)
        begin
            hdr = LONG_MARK;
        end
        if (hdr == LONG_MARK)
        begin
            send_byte(hdr, $urandom_range(7) == 0);
        end
        else
        begin
            sz  = (hdr[1:0] == SIZE_CODE_FOUR) ? 4 : int'(hdr[1:0]);
            cut = ($urandom_range(9) == 0) ? int'($urandom_range(sz)) : -1;
            for (int i = 0; i <= sz; i++)
            begin
                eod = (cut == i) || (i == sz && $urandom_range(7) == 0);
                send_byte((i == 0) ? hdr : 8'($urandom_range(255)), eod);
                if (cut == i)
                begin
                    break;
                end
            end
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_byte     = 8'd0;
        end_of_data = 1'b0;
        snd_idle    = 14;
        rcv_idle    = 47;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_byte(8'h81, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h96, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(LONG_MARK, 1'b0);
        send_byte(8'h75, 1'b0);
        send_byte(LONG_MARK, 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h68, 1'b0);
        send_byte(8'h95, 1'b1);
        send_byte(8'h27, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hA0, 1'b1);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            snd_idle = (ph == 0) ? 14 : (ph == 1) ? 47 : 0;
            rcv_idle = (ph == 0) ? 47 : (ph == 1) ? 14 : 0;
            sent = 0;
            while (sent < BYTES_PER_PHASE)
            begin
                send_item();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && waiting == 0)
        begin
            $display("hid_descriptor_item_parser_core_tb OK");
        end
        else
        begin
            $display("hid_descriptor_item_parser_core_tb NOT OK");
        end
        $finish;
    end

endmodule
